// ===== rtl/frt_pkg.sv =====
// package for the 16-bit free-running timer: codes, register offsets, bit positions, item types
`default_nettype none
package frt_pkg;

    // action codes carried in an input item
    localparam logic [2:0] ACT_READ    = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_SYS_CLK = 3'd2;
    localparam logic [2:0] ACT_EXT_CLK = 3'd3;
    localparam logic [2:0] ACT_CAPTURE = 3'd4;

    // byte register offsets
    localparam logic [3:0] REG_TCR   = 4'd0;
    localparam logic [3:0] REG_TCSR  = 4'd1;
    localparam logic [3:0] REG_FRC_H = 4'd2;
    localparam logic [3:0] REG_FRC_L = 4'd3;
    localparam logic [3:0] REG_OCRA_H = 4'd4;
    localparam logic [3:0] REG_OCRA_L = 4'd5;
    localparam logic [3:0] REG_OCRB_H = 4'd6;
    localparam logic [3:0] REG_OCRB_L = 4'd7;
    localparam logic [3:0] REG_ICR_H = 4'd8;
    localparam logic [3:0] REG_ICR_L = 4'd9;

    // clock select codes in TCR bits 1..0
    localparam logic [1:0] CKS_DIV4  = 2'd0;
    localparam logic [1:0] CKS_DIV8  = 2'd1;
    localparam logic [1:0] CKS_DIV32 = 2'd2;
    localparam logic [1:0] CKS_EXT   = 2'd3;

    // TCR bit positions
    localparam int TCR_ICIE  = 7;
    localparam int TCR_OCIEB = 6;
    localparam int TCR_OCIEA = 5;
    localparam int TCR_OVIE  = 4;
    localparam int TCR_OEB   = 3;
    localparam int TCR_OEA   = 2;

    // TCSR bit positions
    localparam int SR_ICF   = 7;
    localparam int SR_OCFB  = 6;
    localparam int SR_OCFA  = 5;
    localparam int SR_OVF   = 4;
    localparam int SR_OLVLB = 3;
    localparam int SR_OLVLA = 2;
    localparam int SR_IEDG  = 1;
    localparam int SR_CCLRA = 0;

    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [15:0] COMPARE_INIT = 16'hFFFF;
    localparam logic [7:0]  UNUSED_READ  = 8'hFF;

    // one input item
    typedef struct packed {
        logic       edge_rising;
        logic [7:0] write_data;
        logic [3:0] reg_index;
        logic [2:0] action;
    } item_t;

    // one result item
    typedef struct packed {
        logic       pin_b;
        logic       pin_a;
        logic       irq_overflow;
        logic       irq_compare_b;
        logic       irq_compare_a;
        logic       irq_capture;
        logic [7:0] read_data;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/free_running_timer_16bit.sv =====
// top level of the 16-bit free-running timer with compare outputs and input capture
// an accepted item's result is registered in the result register, or in the skid stage while that one waits
// throughput: one item per cycle while the skid stage is empty, set by the single-pass state update in frt_core
// a skid stage keeps taking one more item while the result register waits on m_tready
// reset: synchronous active-low aresetn clears all timer state and both output stages
`default_nettype none
module free_running_timer_16bit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], reg_index[6:3], write_data[14:7], edge_rising[15]
    input  wire logic [15:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[7:0], irq_capture[8], irq_compare_a[9], irq_compare_b[10],
    // irq_overflow[11], pin_a[12], pin_b[13], zero[15:14]
    output logic [15:0]      m_tdata
);

    frt_pkg::item_t   item;
    frt_pkg::result_t result;
    frt_pkg::result_t main_reg;
    frt_pkg::result_t skid_reg;
    logic             main_valid_reg;
    logic             skid_valid_reg;
    logic             accept;

    assign item     = frt_pkg::item_t'(s_tdata);
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {2'b00, main_reg};

    frt_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (accept),
        .item       (item),
        .result     (result)
    );

    // result register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                main_reg       <= skid_reg;
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_reg       <= result;
                main_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_reg       <= result;
            skid_valid_reg <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    // a parked item always has one ahead of it
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid item without result ahead");

    // an item taken behind a stalled result lands in the skid stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && m_tvalid && !m_tready) |=> skid_valid_reg)
        else $error("item lost behind stalled result");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output stages not cleared by reset");
`endif

endmodule
`default_nettype wire

// ===== rtl/frt_core.sv =====
// timer state and the single-pass update for one accepted item
`default_nettype none
module frt_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_valid,
    input  wire frt_pkg::item_t  item,
    output frt_pkg::result_t     result
);

    logic [7:0]  control_reg, control_next;
    logic [7:0]  status_reg, status_next;
    logic [3:0]  seen_reg, seen_next;
    logic [15:0] counter_reg, counter_next;
    logic [15:0] compare_a_reg, compare_a_next;
    logic [15:0] compare_b_reg, compare_b_next;
    logic [15:0] capture_reg, capture_next;
    logic [7:0]  temp_reg, temp_next;
    logic [4:0]  presc_reg, presc_next;
    logic        level_a_reg, level_a_next;
    logic        level_b_reg, level_b_next;

    logic [7:0]  read_data;
    logic [15:0] word;
    logic [3:0]  flag_clr;
    logic [4:0]  presc_inc;
    logic        tick;
    logic        hit_a;
    logic        hit_b;
    logic        clr_count;

    assign word  = {temp_reg, item.write_data};
    assign hit_a = counter_reg == compare_a_reg;
    assign hit_b = counter_reg == compare_b_reg;
    assign clr_count = hit_a && status_reg[frt_pkg::SR_CCLRA];
    assign flag_clr  = ~item.write_data[7:4] & seen_reg;
    assign presc_inc = presc_reg + 5'd1;

    // count pulse from the prescaler or an external pulse
    always_comb begin
        tick = 1'b0;
        if (item.action == frt_pkg::ACT_SYS_CLK) begin
            case (control_reg[1:0])
                frt_pkg::CKS_DIV4:  tick = presc_inc[1:0] == 2'd0;
                frt_pkg::CKS_DIV8:  tick = presc_inc[2:0] == 3'd0;
                frt_pkg::CKS_DIV32: tick = presc_inc == 5'd0;
                default:            tick = 1'b0;
            endcase
        end else if (item.action == frt_pkg::ACT_EXT_CLK) begin
            tick = control_reg[1:0] == frt_pkg::CKS_EXT;
        end
    end

    // next state and read data for the item
    always_comb begin
        control_next   = control_reg;
        status_next    = status_reg;
        seen_next      = seen_reg;
        counter_next   = counter_reg;
        compare_a_next = compare_a_reg;
        compare_b_next = compare_b_reg;
        capture_next   = capture_reg;
        temp_next      = temp_reg;
        presc_next     = presc_reg;
        level_a_next   = level_a_reg;
        level_b_next   = level_b_reg;
        read_data      = 8'd0;

        if (item.action == frt_pkg::ACT_SYS_CLK) begin
            presc_next = presc_inc;
        end

        case (item.action)
            frt_pkg::ACT_READ: begin
                case (item.reg_index)
                    frt_pkg::REG_TCR:  read_data = control_reg;
                    frt_pkg::REG_TCSR: begin
                        read_data = status_reg;
                        seen_next = seen_reg | status_reg[7:4];
                    end
                    frt_pkg::REG_FRC_H: begin
                        read_data = counter_reg[15:8];
                        temp_next = counter_reg[7:0];
                    end
                    frt_pkg::REG_FRC_L:  read_data = temp_reg;
                    frt_pkg::REG_OCRA_H: read_data = compare_a_reg[15:8];
                    frt_pkg::REG_OCRA_L: read_data = compare_a_reg[7:0];
                    frt_pkg::REG_OCRB_H: read_data = compare_b_reg[15:8];
                    frt_pkg::REG_OCRB_L: read_data = compare_b_reg[7:0];
                    frt_pkg::REG_ICR_H: begin
                        read_data = capture_reg[15:8];
                        temp_next = capture_reg[7:0];
                    end
                    frt_pkg::REG_ICR_L: read_data = temp_reg;
                    default:            read_data = frt_pkg::UNUSED_READ;
                endcase
            end
            frt_pkg::ACT_WRITE: begin
                case (item.reg_index)
                    frt_pkg::REG_TCR:  control_next = item.write_data;
                    frt_pkg::REG_TCSR: begin
                        // flags clear only after being read as set
                        status_next = {status_reg[7:4] & ~flag_clr, item.write_data[3:0]};
                        seen_next   = seen_reg & ~flag_clr;
                    end
                    frt_pkg::REG_FRC_H, frt_pkg::REG_OCRA_H, frt_pkg::REG_OCRB_H:
                        temp_next = item.write_data;
                    frt_pkg::REG_FRC_L:  counter_next   = word;
                    frt_pkg::REG_OCRA_L: compare_a_next = word;
                    frt_pkg::REG_OCRB_L: compare_b_next = word;
                    default: ;
                endcase
            end
            frt_pkg::ACT_CAPTURE: begin
                if (item.edge_rising == status_reg[frt_pkg::SR_IEDG]) begin
                    capture_next = counter_reg;
                    status_next[frt_pkg::SR_ICF] = 1'b1;
                end
            end
            default: ;
        endcase

        // match, clear and overflow on a count pulse
        if (tick) begin
            if (hit_a) begin
                status_next[frt_pkg::SR_OCFA] = 1'b1;
                if (control_reg[frt_pkg::TCR_OEA]) begin
                    level_a_next = status_reg[frt_pkg::SR_OLVLA];
                end
            end
            if (hit_b) begin
                status_next[frt_pkg::SR_OCFB] = 1'b1;
                if (control_reg[frt_pkg::TCR_OEB]) begin
                    level_b_next = status_reg[frt_pkg::SR_OLVLB];
                end
            end
            if (counter_reg == frt_pkg::COUNT_MAX && !clr_count) begin
                status_next[frt_pkg::SR_OVF] = 1'b1;
            end
            counter_next = clr_count ? 16'd0 : counter_reg + 16'd1;
        end
    end

    // result seen after the item
    always_comb begin
        result.read_data     = read_data;
        result.irq_capture   = status_next[frt_pkg::SR_ICF] & control_next[frt_pkg::TCR_ICIE];
        result.irq_compare_a = status_next[frt_pkg::SR_OCFA] & control_next[frt_pkg::TCR_OCIEA];
        result.irq_compare_b = status_next[frt_pkg::SR_OCFB] & control_next[frt_pkg::TCR_OCIEB];
        result.irq_overflow  = status_next[frt_pkg::SR_OVF] & control_next[frt_pkg::TCR_OVIE];
        result.pin_a         = level_a_next;
        result.pin_b         = level_b_next;
    end

    // timer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg   <= 8'd0;
            status_reg    <= 8'd0;
            seen_reg      <= 4'd0;
            counter_reg   <= 16'd0;
            compare_a_reg <= frt_pkg::COMPARE_INIT;
            compare_b_reg <= frt_pkg::COMPARE_INIT;
            capture_reg   <= 16'd0;
            temp_reg      <= 8'd0;
            presc_reg     <= 5'd0;
            level_a_reg   <= 1'b0;
            level_b_reg   <= 1'b0;
        end else if (item_valid) begin
            control_reg   <= control_next;
            status_reg    <= status_next;
            seen_reg      <= seen_next;
            counter_reg   <= counter_next;
            compare_a_reg <= compare_a_next;
            compare_b_reg <= compare_b_next;
            capture_reg   <= capture_next;
            temp_reg      <= temp_next;
            presc_reg     <= presc_next;
            level_a_reg   <= level_a_next;
            level_b_reg   <= level_b_next;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the free-running timer: random bus, clock and capture items checked against a predictor
module tb;
    import frt_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // action[2:0], reg_index[6:3], write_data[14:7], edge_rising[15]
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // read_data[7:0], irq_capture[8], irq_compare_a[9], irq_compare_b[10],
    // irq_overflow[11], pin_a[12], pin_b[13], zero[15:14]
    logic [15:0] m_tdata;

    typedef struct {
        item_t it;
        bit    drain_first;
    } pending_t;

    pending_t pending_items[$];
    result_t  timer_results_due[$];

    int error_count    = 0;
    int items_accepted = 0;
    int items_total    = 0;
    int gap_left       = 0;
    int drv_calm       = 0;
    int mon_calm       = 0;

    // stimulus generator bookkeeping
    bit         drain_next = 1'b0;
    logic [1:0] gen_cks    = CKS_DIV4;
    int         gen_count  = 0;

    // shadow copy of the timer state
    logic [7:0]  shadow_tcr;
    logic [7:0]  shadow_tcsr;
    logic [3:0]  shadow_seen;
    logic [15:0] shadow_frc;
    logic [15:0] shadow_ocra;
    logic [15:0] shadow_ocrb;
    logic [15:0] shadow_icr;
    logic [7:0]  shadow_temp;
    logic [4:0]  shadow_presc;
    logic        shadow_pin_a;
    logic        shadow_pin_b;

    free_running_timer_16bit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function void timer_reset();
        shadow_tcr   = '0;
        shadow_tcsr  = '0;
        shadow_seen  = '0;
        shadow_frc   = '0;
        shadow_ocra  = COMPARE_INIT;
        shadow_ocrb  = COMPARE_INIT;
        shadow_icr   = '0;
        shadow_temp  = '0;
        shadow_presc = '0;
        shadow_pin_a = 1'b0;
        shadow_pin_b = 1'b0;
    endfunction

    // one count pulse: compare matches, clear on match a, overflow
    function void count_tick();
        logic hit_a, hit_b, clr, ovf;
        hit_a = shadow_frc == shadow_ocra;
        hit_b = shadow_frc == shadow_ocrb;
        clr   = hit_a && shadow_tcsr[SR_CCLRA];
        ovf   = (shadow_frc == COUNT_MAX) && !clr;
        if (hit_a) begin
            shadow_tcsr[SR_OCFA] = 1'b1;
            if (shadow_tcr[TCR_OEA])
                shadow_pin_a = shadow_tcsr[SR_OLVLA];
        end
        if (hit_b) begin
            shadow_tcsr[SR_OCFB] = 1'b1;
            if (shadow_tcr[TCR_OEB])
                shadow_pin_b = shadow_tcsr[SR_OLVLB];
        end
        if (ovf)
            shadow_tcsr[SR_OVF] = 1'b1;
        shadow_frc = clr ? 16'h0000 : shadow_frc + 16'h0001;
    endfunction

    // advance the shadow state by one item and form the expected result
    function result_t timer_step_result(input item_t it);
        result_t     r;
        logic [15:0] word;
        logic [3:0]  clr;
        logic [4:0]  mask;
        r    = '0;
        word = {shadow_temp, it.write_data};
        case (it.action)
            ACT_READ: begin
                case (it.reg_index)
                    REG_TCR:    r.read_data = shadow_tcr;
                    REG_TCSR: begin
                        shadow_seen = shadow_seen | shadow_tcsr[7:4];
                        r.read_data = shadow_tcsr;
                    end
                    REG_FRC_H: begin
                        shadow_temp = shadow_frc[7:0];
                        r.read_data = shadow_frc[15:8];
                    end
                    REG_FRC_L:  r.read_data = shadow_temp;
                    REG_OCRA_H: r.read_data = shadow_ocra[15:8];
                    REG_OCRA_L: r.read_data = shadow_ocra[7:0];
                    REG_OCRB_H: r.read_data = shadow_ocrb[15:8];
                    REG_OCRB_L: r.read_data = shadow_ocrb[7:0];
                    REG_ICR_H: begin
                        shadow_temp = shadow_icr[7:0];
                        r.read_data = shadow_icr[15:8];
                    end
                    REG_ICR_L:  r.read_data = shadow_temp;
                    default:    r.read_data = UNUSED_READ;
                endcase
            end
            ACT_WRITE: begin
                case (it.reg_index)
                    REG_TCR: shadow_tcr = it.write_data;
                    REG_TCSR: begin
                        // a flag clears only if seen set and now written zero
                        clr = ~it.write_data[7:4] & shadow_seen;
                        shadow_tcsr = {shadow_tcsr[7:4] & ~clr, it.write_data[3:0]};
                        shadow_seen = shadow_seen & ~clr;
                    end
                    REG_FRC_H, REG_OCRA_H, REG_OCRB_H: shadow_temp = it.write_data;
                    REG_FRC_L:  shadow_frc  = word;
                    REG_OCRA_L: shadow_ocra = word;
                    REG_OCRB_L: shadow_ocrb = word;
                    default: ;
                endcase
            end
            ACT_SYS_CLK: begin
                shadow_presc = shadow_presc + 5'd1;
                case (shadow_tcr[1:0])
                    CKS_DIV4:  mask = 5'h03;
                    CKS_DIV8:  mask = 5'h07;
                    CKS_DIV32: mask = 5'h1F;
                    default:   mask = 5'h00;
                endcase
                if (shadow_tcr[1:0] != CKS_EXT && (shadow_presc & mask) == 5'h00)
                    count_tick();
            end
            ACT_EXT_CLK: begin
                if (shadow_tcr[1:0] == CKS_EXT)
                    count_tick();
            end
            ACT_CAPTURE: begin
                if (it.edge_rising == shadow_tcsr[SR_IEDG]) begin
                    shadow_icr = shadow_frc;
                    shadow_tcsr[SR_ICF] = 1'b1;
                end
            end
            default: ;
        endcase
        r.irq_capture   = shadow_tcsr[SR_ICF]  & shadow_tcr[TCR_ICIE];
        r.irq_compare_a = shadow_tcsr[SR_OCFA] & shadow_tcr[TCR_OCIEA];
        r.irq_compare_b = shadow_tcsr[SR_OCFB] & shadow_tcr[TCR_OCIEB];
        r.irq_overflow  = shadow_tcsr[SR_OVF]  & shadow_tcr[TCR_OVIE];
        r.pin_a         = shadow_pin_a;
        r.pin_b         = shadow_pin_b;
        return r;
    endfunction

    // wait length for one item, with occasional stretches of no waiting
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function void check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            error_count++;
        end
    endfunction

    // driver: predict each accepted item, then launch the next pending one
    always @(posedge aclk) begin : driver
        pending_t launch;
        logic     taken;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
            timer_reset();
        end else begin
            taken = s_tvalid && s_tready;
            if (taken) begin
                timer_results_due.push_back(timer_step_result(item_t'(s_tdata)));
                items_accepted++;
            end
            if (s_tvalid && !taken) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain_first && timer_results_due.size() != 0)) begin
                launch = pending_items.pop_front();
                s_tdata  <= launch.it;
                s_tvalid <= 1'b1;
                gap_left <= draw_wait(drv_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin : monitor
        result_t want, got;
        int      hold;
        int      stall_left;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            hold = stall_left;
            if (m_tvalid && m_tready) begin
                if (timer_results_due.size() == 0) begin
                    $error("result with no pending expectation: %h", m_tdata);
                    error_count++;
                end else begin
                    want = timer_results_due.pop_front();
                    got  = result_t'(m_tdata[$bits(result_t)-1:0]);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("irq_capture", want.irq_capture, got.irq_capture);
                    check_field("irq_compare_a", want.irq_compare_a, got.irq_compare_a);
                    check_field("irq_compare_b", want.irq_compare_b, got.irq_compare_b);
                    check_field("irq_overflow", want.irq_overflow, got.irq_overflow);
                    check_field("pin_a", want.pin_a, got.pin_a);
                    check_field("pin_b", want.pin_b, got.pin_b);
                    check_field("pad", 0, m_tdata[15:$bits(result_t)]);
                end
                hold = draw_wait(mon_calm);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                stall_left = hold - 1;
            end else begin
                m_tready <= 1'b1;
                stall_left = 0;
            end
        end
    end

    // queue one item, tracking the clock select it leaves behind
    task automatic put(input logic [2:0] act, input logic [3:0] idx,
                       input logic [7:0] data, input logic edge_rise);
        pending_t p;
        p.it.action      = act;
        p.it.reg_index   = idx;
        p.it.write_data  = data;
        p.it.edge_rising = edge_rise;
        p.drain_first    = drain_next;
        drain_next       = 1'b0;
        pending_items.push_back(p);
        if (act == ACT_WRITE && idx == REG_TCR)
            gen_cks = data[1:0];
        if (act <= ACT_CAPTURE)
            gen_count++;
    endtask

    task automatic wr(input logic [3:0] idx, input logic [7:0] data);
        put(ACT_WRITE, idx, data, 1'($urandom_range(0, 1)));
    endtask

    task automatic rd(input logic [3:0] idx);
        put(ACT_READ, idx, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic wr16(input logic [3:0] hi, input logic [3:0] lo, input logic [15:0] v);
        wr(hi, v[15:8]);
        wr(lo, v[7:0]);
    endtask

    // clock items for the given number of counter ticks; with the external clock some are system items and give none
    task automatic run_clock(input int ticks);
        int i, per;
        case (gen_cks)
            CKS_DIV4:  per = 4;
            CKS_DIV8:  per = 8;
            CKS_DIV32: per = 32;
            default:   per = 1;
        endcase
        for (i = 0; i < ticks * per; i++)
            put((gen_cks == CKS_EXT && $urandom_range(0, 3) != 0) ? ACT_EXT_CLK : ACT_SYS_CLK,
                4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    endtask

    // random sequences biased toward compare matches, overflow and flag handling
    task automatic fill_random(input int budget);
        int          kind, i, d1, d2;
        logic [15:0] v;
        logic [7:0]  b;
        while (gen_count < budget) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                // new timer mode
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0)
                    b[1:0] = CKS_EXT;
                if ($urandom_range(0, 5) == 0)
                    drain_next = 1'b1;
                wr(REG_TCR, b);
            end else if (kind < 8) begin
                // load counter and both compares close to it, then count through
                v = ($urandom_range(0, 2) == 0) ? COUNT_MAX - 16'($urandom_range(0, 3))
                                                : 16'($urandom_range(0, 65535));
                d1 = $urandom_range(0, 3);
                d2 = $urandom_range(0, 3);
                if ($urandom_range(0, 1) == 0)
                    wr(REG_TCSR, {4'hF, 4'($urandom_range(0, 15))});
                wr16(REG_FRC_H, REG_FRC_L, v);
                wr16(REG_OCRA_H, REG_OCRA_L, v + 16'(d1));
                wr16(REG_OCRB_H, REG_OCRB_L, v + 16'(d2));
                run_clock(((d1 > d2) ? d1 : d2) + 2);
            end else if (kind < 11) begin
                // read status then clear flags
                rd(REG_TCSR);
                if ($urandom_range(0, 3) == 0)
                    run_clock(1);
                b = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 2) != 0)
                    b[7:4] = 4'h0;
                wr(REG_TCSR, b);
            end else if (kind < 13) begin
                // capture edges and a 16-bit read of the capture register
                if ($urandom_range(0, 1) == 0)
                    wr(REG_TCSR, {4'hF, 4'($urandom_range(0, 15))});
                for (i = 0; i < $urandom_range(1, 3); i++) begin
                    put(ACT_CAPTURE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
                    run_clock($urandom_range(0, 1));
                end
                rd(REG_ICR_H);
                rd(REG_ICR_L);
            end else if (kind < 15) begin
                // 16-bit counter read with counting in between, compare reads
                rd(REG_FRC_H);
                run_clock($urandom_range(0, 1));
                rd(REG_FRC_L);
                rd(4'($urandom_range(REG_OCRA_H, REG_OCRB_L)));
            end else if (kind < 17) begin
                run_clock($urandom_range(1, 4));
            end else begin
                // noise and broken sequences
                for (i = 0; i < $urandom_range(1, 4); i++)
                    put(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // stimulus, reset and end of run
    initial begin
        aresetn = 1'b0;

        // reset values and extremes
        rd(REG_TCR);
        rd(REG_TCSR);
        rd(REG_OCRA_H);
        rd(REG_OCRA_L);
        // every enable, external clock, both output levels high
        wr(REG_TCR, 8'hFF);
        wr(REG_TCSR, 8'h0C);
        wr16(REG_FRC_H, REG_FRC_L, COUNT_MAX);
        // leaving 0xFFFF hits both compares and overflows
        put(ACT_EXT_CLK, REG_TCR, 8'h00, 1'b0);
        // falling edge captures, rising edge of the wrong polarity is ignored
        put(ACT_CAPTURE, REG_TCR, 8'h00, 1'b0);
        put(ACT_CAPTURE, REG_TCR, 8'hFF, 1'b1);
        rd(REG_ICR_H);
        rd(REG_ICR_L);
        // read flags as set, then clear them all and set clear-on-match
        rd(REG_TCSR);
        wr(REG_TCSR, 8'h01);
        rd(REG_FRC_H);
        rd(REG_FRC_L);
        // phi/4: one tick from a run of system clock items, external pulse ignored
        wr(REG_TCR, 8'h00);
        run_clock(1);
        put(ACT_EXT_CLK, REG_TCR, 8'h00, 1'b1);
        // undefined action, unused offsets, write to the capture register
        put(3'd7, 4'hF, 8'hFF, 1'b1);
        wr(4'hC, 8'hAA);
        rd(4'hF);
        wr(REG_ICR_L, 8'h55);

        // random part, starting with a full drain of the pipeline
        drain_next = 1'b1;
        fill_random(gen_count + 1650);
        items_total = pending_items.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted != items_total)
            @(posedge aclk);
        while (timer_results_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (error_count == 0 && timer_results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
